// File: src/postfix_expression_evaluator_core_defines.svh
// Assertion macros for the checker file of the evaluator.
`ifndef POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH
`define POSTFIX_EXPRESSION_EVALUATOR_CORE_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PFE_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled during reset.
`define PFE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// File: src/pfe_pkg.sv
// Shared types, codes and constants of the postfix expression evaluator.
package pfe_pkg;

  localparam int DATA_W            = 32;
  localparam int SYM_W             = 8;
  localparam int ERR_W             = 2;
  localparam int STACK_DEPTH_DEF   = 16;

  localparam logic [SYM_W-1:0] SYM_ADD   = 8'h2B;
  localparam logic [SYM_W-1:0] SYM_SUB   = 8'h2D;
  localparam logic [SYM_W-1:0] SYM_MUL   = 8'h2A;
  localparam logic [SYM_W-1:0] SYM_DIV   = 8'h2F;
  localparam logic [SYM_W-1:0] SYM_ZERO  = 8'h30;

  localparam logic [DATA_W-1:0] EMPTY_VALUE = {DATA_W{1'b1}};

  localparam logic [ERR_W-1:0] ERR_NONE  = 2'd0;
  localparam logic [ERR_W-1:0] ERR_UNDER = 2'd1;
  localparam logic [ERR_W-1:0] ERR_OVER  = 2'd2;
  localparam logic [ERR_W-1:0] ERR_DIVZ  = 2'd3;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_POP_R,
    ST_CAP_R,
    ST_POP_L,
    ST_CAP_L,
    ST_EXEC,
    ST_DIV,
    ST_PUSH,
    ST_PUSH_SYM,
    ST_FIN_POP,
    ST_FIN_CAP,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;
    logic pop;
    logic cap_right;
    logic cap_left;
    logic alu;
    logic div_start;
    logic div_cap;
    logic push;
    logic push_sym;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic is_op;
    logic is_div;
    logic last;
    logic div_done;
    logic out_busy;
  } stat_t;

endpackage

// File: src/pfe_if.sv
// Valid/ready channel interfaces for input symbols and evaluation results.
interface pfe_in_if;
  logic                          valid;
  logic                          ready;
  logic [pfe_pkg::SYM_W-1:0]     symbol;
  logic                          last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink   (input valid, input symbol, input last, output ready);
endinterface

interface pfe_out_if;
  logic                          valid;
  logic                          ready;
  logic signed [pfe_pkg::DATA_W-1:0] value;
  logic [pfe_pkg::ERR_W-1:0]     error;

  modport source (output valid, output value, output error, input ready);
  modport sink   (input valid, input value, input error, output ready);
endinterface

// File: src/pfe_divider.sv
// Iterative restoring divider of unsigned magnitudes, one quotient bit a cycle.
module pfe_divider (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [pfe_pkg::DATA_W-1:0]  dividend_i,
  input  logic [pfe_pkg::DATA_W-1:0]  divisor_i,
  output logic                        done_o,
  output logic [pfe_pkg::DATA_W-1:0]  quotient_o
);

  localparam int DW     = pfe_pkg::DATA_W;
  localparam int STEP_W = $clog2(DW);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic [DW-1:0]     rem_q, rem_d;
  logic [DW-1:0]     quo_q, quo_d;
  logic [DW-1:0]     dsr_q, dsr_d;
  logic [DW:0]       shifted;
  logic [DW:0]       diff;

  always_comb begin
    shifted = {rem_q, quo_q[DW-1]};
    diff    = shifted - {1'b0, dsr_q};
    busy_d  = busy_q;
    done_d  = 1'b0;
    step_d  = step_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    dsr_d   = dsr_q;
    if (start_i) begin
      busy_d = 1'b1;
      step_d = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dsr_d  = divisor_i;
    end else if (busy_q) begin
      if (!diff[DW]) begin
        rem_d = diff[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b1};
      end else begin
        rem_d = shifted[DW-1:0];
        quo_d = {quo_q[DW-2:0], 1'b0};
      end
      step_d = step_q + STEP_W'(1);
      if (step_q == STEP_W'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    quo_q <= quo_d;
    dsr_q <= dsr_d;
  end

  assign done_o     = done_q;
  assign quotient_o = quo_q;

endmodule

// File: src/pfe_datapath.sv
// Operand stack memory, operand registers, arithmetic and result register.
module pfe_datapath #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  pfe_pkg::cmd_t                      cmd_i,
  output pfe_pkg::stat_t                     stat_o,
  input  logic [pfe_pkg::SYM_W-1:0]          symbol_i,
  input  logic                               last_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic signed [pfe_pkg::DATA_W-1:0]  out_value_o,
  output logic [pfe_pkg::ERR_W-1:0]          out_error_o
);

  localparam int DW     = pfe_pkg::DATA_W;
  localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W = $clog2(STACK_DEPTH);

  logic [DW-1:0]              stack_mem [STACK_DEPTH];
  logic [CNT_W-1:0]           count_q, count_d;
  logic [pfe_pkg::ERR_W-1:0]  err_q, err_d;
  logic                       out_valid_q, out_valid_d;
  logic [pfe_pkg::SYM_W-1:0]  sym_q;
  logic                       last_q;
  logic                       pop_empty_q;
  logic [DW-1:0]              rd_data_q;
  logic [DW-1:0]              right_q;
  logic [DW-1:0]              left_q;
  logic [DW-1:0]              res_q;
  logic                       div_neg_q;
  logic                       div_zero_q;
  logic [DW-1:0]              out_value_q;
  logic [pfe_pkg::ERR_W-1:0]  out_error_q;

  logic                       empty;
  logic                       full;
  logic [CNT_W-1:0]           count_dec;
  logic [ADDR_W-1:0]          rd_addr;
  logic [ADDR_W-1:0]          wr_addr;
  logic [DW-1:0]              sym_val;
  logic [DW-1:0]              push_val;
  logic [DW-1:0]              product;
  logic [DW-1:0]              mag_l;
  logic [DW-1:0]              mag_r;
  logic [DW-1:0]              quotient;
  logic [DW-1:0]              div_res;
  logic                       div_done;
  logic                       is_op;

  assign empty     = (count_q == '0);
  assign full      = (count_q == CNT_W'(STACK_DEPTH));
  assign count_dec = count_q - CNT_W'(1);
  assign rd_addr   = count_dec[ADDR_W-1:0];
  assign wr_addr   = count_q[ADDR_W-1:0];
  assign sym_val   = {{(DW - pfe_pkg::SYM_W){1'b0}}, sym_q}
                   - {{(DW - pfe_pkg::SYM_W){1'b0}}, pfe_pkg::SYM_ZERO};
  assign push_val  = cmd_i.push_sym ? sym_val : res_q;
  assign product   = left_q * right_q;
  assign mag_l     = left_q[DW-1] ? (DW'(0) - left_q) : left_q;
  assign mag_r     = right_q[DW-1] ? (DW'(0) - right_q) : right_q;
  assign div_res   = div_zero_q ? '0 : (div_neg_q ? (DW'(0) - quotient) : quotient);

  assign is_op = (sym_q == pfe_pkg::SYM_ADD) || (sym_q == pfe_pkg::SYM_SUB) ||
                 (sym_q == pfe_pkg::SYM_MUL) || (sym_q == pfe_pkg::SYM_DIV);

  pfe_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (mag_l),
    .divisor_i  (mag_r),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  always_comb begin
    count_d     = count_q;
    err_d       = err_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_i.pop) begin
      if (empty) begin
        if (err_q == pfe_pkg::ERR_NONE) err_d = pfe_pkg::ERR_UNDER;
      end else begin
        count_d = count_dec;
      end
    end
    if (cmd_i.div_start && (right_q == '0) && (err_q == pfe_pkg::ERR_NONE)) begin
      err_d = pfe_pkg::ERR_DIVZ;
    end
    if (cmd_i.push) begin
      if (full) begin
        if (err_q == pfe_pkg::ERR_NONE) err_d = pfe_pkg::ERR_OVER;
      end else begin
        count_d = count_q + CNT_W'(1);
      end
    end
    if (cmd_i.emit) begin
      out_valid_d = 1'b1;
      count_d     = '0;
      err_d       = pfe_pkg::ERR_NONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      err_q       <= pfe_pkg::ERR_NONE;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full) begin
      stack_mem[wr_addr] <= push_val;
    end
    rd_data_q <= stack_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q  <= symbol_i;
      last_q <= last_i;
    end
    if (cmd_i.pop) begin
      pop_empty_q <= empty;
    end
    if (cmd_i.cap_right) begin
      right_q <= pop_empty_q ? pfe_pkg::EMPTY_VALUE : rd_data_q;
    end
    if (cmd_i.cap_left) begin
      left_q <= pop_empty_q ? pfe_pkg::EMPTY_VALUE : rd_data_q;
    end
    if (cmd_i.div_start) begin
      div_neg_q  <= left_q[DW-1] ^ right_q[DW-1];
      div_zero_q <= (right_q == '0);
    end
    if (cmd_i.alu) begin
      case (sym_q)
        pfe_pkg::SYM_ADD: res_q <= left_q + right_q;
        pfe_pkg::SYM_SUB: res_q <= left_q - right_q;
        default:          res_q <= product;
      endcase
    end else if (cmd_i.div_cap) begin
      res_q <= div_res;
    end
    if (cmd_i.emit) begin
      out_value_q <= right_q;
      out_error_q <= err_q;
    end
  end

  assign stat_o.is_op    = is_op;
  assign stat_o.is_div   = (sym_q == pfe_pkg::SYM_DIV);
  assign stat_o.last     = last_q;
  assign stat_o.div_done = div_done;
  assign stat_o.out_busy = out_valid_q;

  assign out_valid_o = out_valid_q;
  assign out_value_o = out_value_q;
  assign out_error_o = out_error_q;

endmodule

// File: src/pfe_ctrl.sv
// Sequencer that steps the datapath through pops, arithmetic, push and emit.
module pfe_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  pfe_pkg::stat_t  stat_i,
  output pfe_pkg::cmd_t   cmd_o
);

  pfe_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pfe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    case (state_q)
      pfe_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = pfe_pkg::ST_DECODE;
        end
      end
      pfe_pkg::ST_DECODE: begin
        state_d = stat_i.is_op ? pfe_pkg::ST_POP_R : pfe_pkg::ST_PUSH_SYM;
      end
      pfe_pkg::ST_POP_R: begin
        cmd_o.pop = 1'b1;
        state_d   = pfe_pkg::ST_CAP_R;
      end
      pfe_pkg::ST_CAP_R: begin
        cmd_o.cap_right = 1'b1;
        state_d         = pfe_pkg::ST_POP_L;
      end
      pfe_pkg::ST_POP_L: begin
        cmd_o.pop = 1'b1;
        state_d   = pfe_pkg::ST_CAP_L;
      end
      pfe_pkg::ST_CAP_L: begin
        cmd_o.cap_left = 1'b1;
        state_d        = pfe_pkg::ST_EXEC;
      end
      pfe_pkg::ST_EXEC: begin
        if (stat_i.is_div) begin
          cmd_o.div_start = 1'b1;
          state_d         = pfe_pkg::ST_DIV;
        end else begin
          cmd_o.alu = 1'b1;
          state_d   = pfe_pkg::ST_PUSH;
        end
      end
      pfe_pkg::ST_DIV: begin
        if (stat_i.div_done) begin
          cmd_o.div_cap = 1'b1;
          state_d       = pfe_pkg::ST_PUSH;
        end
      end
      pfe_pkg::ST_PUSH: begin
        cmd_o.push = 1'b1;
        state_d    = stat_i.last ? pfe_pkg::ST_FIN_POP : pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_PUSH_SYM: begin
        cmd_o.push     = 1'b1;
        cmd_o.push_sym = 1'b1;
        state_d        = stat_i.last ? pfe_pkg::ST_FIN_POP : pfe_pkg::ST_IDLE;
      end
      pfe_pkg::ST_FIN_POP: begin
        cmd_o.pop = 1'b1;
        state_d   = pfe_pkg::ST_FIN_CAP;
      end
      pfe_pkg::ST_FIN_CAP: begin
        cmd_o.cap_right = 1'b1;
        state_d         = pfe_pkg::ST_EMIT;
      end
      pfe_pkg::ST_EMIT: begin
        if (!stat_i.out_busy) begin
          cmd_o.emit = 1'b1;
          state_d    = pfe_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfe_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// File: src/postfix_expression_evaluator_core.sv
// Top level of the postfix expression evaluator: controller plus datapath.
//
//   channel  | dir | payload                 | handshake
//   in_i     | in  | symbol[7:0], last       | valid/ready
//   out_o    | out | value[31:0], error[1:0] | valid/ready
//
// One word at a time: an operand is loaded, decoded and pushed; + - * pop both
// operands, compute and push; / waits on the 32-step restoring divider. A word with
// last then pops the final value and loads the output register.
// Reset clears the stack count, sticky error, controller and output valid.
// A result waiting in the output register stalls only the next emit.
module postfix_expression_evaluator_core #(
  parameter int STACK_DEPTH = pfe_pkg::STACK_DEPTH_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfe_in_if.sink    in_i,
  pfe_out_if.source out_o
);

  pfe_pkg::cmd_t  cmd;
  pfe_pkg::stat_t stat;

  pfe_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  pfe_datapath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .symbol_i    (in_i.symbol),
    .last_i      (in_i.last),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .out_value_o (out_o.value),
    .out_error_o (out_o.error)
  );

endmodule

// File: src/pfe_checker.sv
// Port-level assertions for the evaluator and their bind to the top level.
`include "postfix_expression_evaluator_core_defines.svh"

module pfe_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_i,
  input logic                        out_valid_i,
  input logic                        out_ready_i,
  input logic [pfe_pkg::DATA_W-1:0]  out_value_i,
  input logic [pfe_pkg::ERR_W-1:0]   out_error_i
);

  `PFE_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_value_i) && $stable(out_error_i))
  `PFE_ASSERT_NEXT(a_one_word, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `PFE_ASSERT_NOW(a_emit_busy, clk_i, rst_ni, $rose(out_valid_i), !$past(in_ready_i))

endmodule

bind postfix_expression_evaluator_core pfe_checker u_pfe_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_value_i (out_o.value),
  .out_error_i (out_o.error)
);

// File: verif/testbench.sv
// Self-checking testbench for the postfix expression evaluator core.
module testbench;
  import pfe_pkg::*;

  class eval_scoreboard;
    typedef struct {
      logic [DATA_W-1:0] value;
      logic [ERR_W-1:0]  error;
    } result_t;

    logic [DATA_W-1:0] stack_mem [STACK_DEPTH_DEF];
    int unsigned       depth;
    logic [ERR_W-1:0]  sticky;
    result_t           expected_q [$];
    int                mismatches;
    int                words;
    int                results;
    int                code_seen [4];

    function new();
      depth = 0;
      sticky = ERR_NONE;
      mismatches = 0;
      words = 0;
      results = 0;
      foreach (code_seen[i]) code_seen[i] = 0;
      foreach (stack_mem[i]) stack_mem[i] = '0;
    endfunction

    function void flag(logic [ERR_W-1:0] code);
      if (sticky == ERR_NONE) sticky = code;
    endfunction

    function void push(logic [DATA_W-1:0] v);
      if (depth >= STACK_DEPTH_DEF) begin
        flag(ERR_OVER);
        return;
      end
      stack_mem[depth] = v;
      depth++;
    endfunction

    function logic [DATA_W-1:0] pop();
      if (depth == 0) begin
        flag(ERR_UNDER);
        return EMPTY_VALUE;
      end
      depth--;
      return stack_mem[depth];
    endfunction

    function logic [DATA_W-1:0] quotient(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      logic [DATA_W-1:0] ma;
      logic [DATA_W-1:0] mb;
      logic [DATA_W-1:0] q;
      ma = a[DATA_W-1] ? -a : a;
      mb = b[DATA_W-1] ? -b : b;
      if (mb == '0) begin
        flag(ERR_DIVZ);
        return '0;
      end
      q = ma / mb;
      return (a[DATA_W-1] ^ b[DATA_W-1]) ? -q : q;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
    endfunction

    function void note_word(logic [SYM_W-1:0] sym, logic fin);
      logic [DATA_W-1:0] rhs;
      logic [DATA_W-1:0] lhs;
      logic [DATA_W-1:0] res;
      result_t           r;
      words++;
      case (sym)
        SYM_ADD, SYM_SUB, SYM_MUL, SYM_DIV: begin
          rhs = pop();
          lhs = pop();
          case (sym)
            SYM_ADD: res = lhs + rhs;
            SYM_SUB: res = lhs - rhs;
            SYM_MUL: res = lhs * rhs;
            default: res = quotient(lhs, rhs);
          endcase
          push(res);
        end
        default: push(DATA_W'(sym) - DATA_W'(SYM_ZERO));
      endcase
      if (fin) begin
        r.value = pop();
        r.error = sticky;
        expected_q.push_back(r);
        depth = 0;
        sticky = ERR_NONE;
      end
    endfunction

    function void check_result(logic [DATA_W-1:0] value, logic [ERR_W-1:0] error);
      result_t exp_r;
      results++;
      if (!$isunknown(error)) code_seen[error]++;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected result value=%0d error=%0d",
                         $signed(value), error));
        return;
      end
      exp_r = expected_q.pop_front();
      if (value !== exp_r.value || error !== exp_r.error)
        report($sformatf("result mismatch: expected value=%0d error=%0d, got value=%0d error=%0d",
                         $signed(exp_r.value), exp_r.error, $signed(value), error));
    endfunction
  endclass

  logic clk_i;
  logic rst_ni;

  pfe_in_if  in_if ();
  pfe_out_if out_if ();

  postfix_expression_evaluator_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  eval_scoreboard   sb;
  int               send_idle_pct;
  int               recv_stall_pct;
  logic             hold_off;
  int               exprs;
  logic [SYM_W-1:0] expr_q [$];

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  always @(negedge clk_i) begin
    out_if.ready <= !hold_off && ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready) sb.check_result(out_if.value, out_if.error);
  end

  function automatic logic [SYM_W-1:0] digit(int n);
    return SYM_ZERO + SYM_W'(n);
  endfunction

  function automatic logic [SYM_W-1:0] pick_operator();
    case ($urandom_range(0, 3))
      0: return SYM_ADD;
      1: return SYM_SUB;
      2: return SYM_MUL;
      default: return SYM_DIV;
    endcase
  endfunction

  function automatic logic [SYM_W-1:0] pick_operand();
    logic [SYM_W-1:0] s;
    if ($urandom_range(0, 99) < 70) return digit($urandom_range(0, 9));
    do
      s = SYM_W'($urandom_range(0, 255));
    while (s == SYM_ADD || s == SYM_SUB || s == SYM_MUL || s == SYM_DIV);
    return s;
  endfunction

  task automatic send_word(logic [SYM_W-1:0] sym, logic fin);
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_if.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_if.valid  <= 1'b1;
    in_if.symbol <= sym;
    in_if.last   <= fin;
    do
      @(posedge clk_i);
    while (!in_if.ready);
    sb.note_word(sym, fin);
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) send_word(expr_q[i], i == expr_q.size() - 1);
    exprs++;
  endtask

  task automatic build_random_expr();
    int shape;
    int n;
    int d;
    expr_q.delete();
    shape = $urandom_range(0, 99);
    if (shape < 70) begin
      n = $urandom_range(1, 8);
      d = 0;
      repeat (n) begin
        expr_q.push_back(pick_operand());
        d++;
        while (d >= 2 && $urandom_range(0, 1) == 1) begin
          expr_q.push_back(pick_operator());
          d--;
        end
      end
      while (d > 1) begin
        expr_q.push_back(pick_operator());
        d--;
      end
    end else if (shape < 82) begin
      // deep stack: past the depth when n exceeds it
      n = $urandom_range(14, 19);
      repeat (n) expr_q.push_back(pick_operand());
      repeat (n - 1) expr_q.push_back(pick_operator());
    end else begin
      repeat ($urandom_range(1, 6)) expr_q.push_back(SYM_W'($urandom_range(0, 255)));
    end
  endtask

  task automatic run_phase(int idle, int stall, int n_words);
    int start;
    send_idle_pct = idle;
    recv_stall_pct = stall;
    start = sb.words;
    while (sb.words - start < n_words) begin
      build_random_expr();
      send_expr();
    end
  endtask

  initial begin
    rst_ni         = 1'b0;
    in_if.valid    = 1'b0;
    in_if.symbol   = '0;
    in_if.last     = 1'b0;
    out_if.ready   = 1'b0;
    hold_off       = 1'b0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    exprs          = 0;
    sb = new();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // extreme symbols, every operator, negative truncation
    expr_q = {8'd0, 8'd255, SYM_SUB, digit(3), SYM_MUL, digit(4), SYM_ADD, digit(7), SYM_DIV};
    send_expr();
    expr_q = {digit(5), digit(0), SYM_DIV};
    send_expr();
    expr_q = {SYM_ADD};
    send_expr();
    // build the most negative value, then divide it by minus one
    expr_q = {SYM_ZERO + 8'd128, SYM_ZERO + 8'd128, SYM_MUL, SYM_ZERO + 8'd128, SYM_MUL,
              SYM_ZERO + 8'd128, SYM_MUL, digit(8), SYM_MUL, digit(1), digit(2), SYM_SUB,
              SYM_DIV};
    send_expr();

    run_phase(0, 0, 130);
    run_phase(83, 0, 110);
    run_phase(0, 83, 110);
    run_phase(23, 23, 110);

    // hold the receiver off so results back up and the input stalls
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        @(posedge clk_i);
        hold_off = 1'b1;
        repeat (400) @(posedge clk_i);
        hold_off = 1'b0;
      end
      begin
        repeat (40) begin
          expr_q = {digit($urandom_range(0, 9))};
          send_expr();
        end
      end
    join

    @(negedge clk_i);
    in_if.valid <= 1'b0;
    while (sb.expected_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);

    $display("Evaluated %0d expressions over %0d words, %0d results checked.",
             exprs, sb.words, sb.results);
    $display("Results by code: ok %0d, underflow %0d, overflow %0d, divide by zero %0d.",
             sb.code_seen[ERR_NONE], sb.code_seen[ERR_UNDER], sb.code_seen[ERR_OVER],
             sb.code_seen[ERR_DIVZ]);
    if (sb.mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end
endmodule
